// ----- sv/led_matrix_double_buffer_scanner_assert.svh -----
// -----------------------------------------------------------------------------
// LED matrix scanner assertion macros
// Shorthand for clocked assertions that are disabled while reset is held.
// -----------------------------------------------------------------------------
`ifndef LED_MATRIX_DOUBLE_BUFFER_SCANNER_ASSERT_SVH
`define LED_MATRIX_DOUBLE_BUFFER_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMDBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMDBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lmdbs_pkg.sv -----
// -----------------------------------------------------------------------------
// LED matrix scanner package
// Request and result types, action codes and shared constants.
// -----------------------------------------------------------------------------
package lmdbs_pkg;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_SWAP  = 2'd2;

    localparam logic [3:0] DIM_RESET = 4'd4;
    localparam logic [4:0] SCAN_LAST = 5'h1f;
    localparam logic [2:0] ROW_LAST  = 3'd7;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] row_index;
        logic [7:0] row_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0] port_b_value;
        logic [5:0] port_c_value;
        logic [7:0] port_d_value;
        logic       shown_buffer;
    } t_out_item;

    // Write port of the row buffer: slot is {buffer, row}.
    typedef struct packed {
        logic       en;
        logic [3:0] addr;
        logic [7:0] data;
    } t_buf_wr;

endpackage

// ----- sv/lmdbs_row_buf.sv -----
// -----------------------------------------------------------------------------
// LED matrix row buffer
// Two frames of eight rows, each with its row byte and lit LED count.
// -----------------------------------------------------------------------------
module lmdbs_row_buf
    import lmdbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_buf_wr    i_wr,
    input  logic [3:0] i_rd_addr,
    output logic [7:0] o_rd_row,
    output logic [3:0] o_rd_lit
);

    logic [7:0] r_rows [16];
    logic [3:0] r_lits [16];
    logic [3:0] n_lit;

    always_comb begin
        n_lit = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n_lit = n_lit + {3'd0, i_wr.data[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_rows[i] <= 8'd0;
                r_lits[i] <= 4'd0;
            end
        end else if (i_wr.en) begin
            r_rows[i_wr.addr] <= i_wr.data;
            r_lits[i_wr.addr] <= n_lit;
        end
    end

    assign o_rd_row = r_rows[i_rd_addr];
    assign o_rd_lit = r_lits[i_rd_addr];

endmodule

// ----- sv/led_matrix_double_buffer_scanner.sv -----
// -----------------------------------------------------------------------------
// LED matrix double buffer scanner
// A scan tick's request is registered, then its result is registered once the output is free.
// Throughput: one request per cycle; a tick waits only while the previous result is held.
// Reset: synchronous; frames, counter and swap state clear, the dim threshold returns to 4.
// -----------------------------------------------------------------------------
`include "led_matrix_double_buffer_scanner_assert.svh"

module led_matrix_double_buffer_scanner
    import lmdbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data
);

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    logic [4:0] r_scan;
    logic       r_front;
    logic       r_pending;
    logic       r_lock;
    logic [3:0] r_dim;

    logic       w_is_tick;
    logic       w_out_free;
    logic       w_advance;
    logic       w_do_tick;
    logic       w_do_write;
    logic       w_do_swap;
    logic       w_swap_now;
    logic [2:0] w_col;
    logic [7:0] w_rd_row;
    logic [3:0] w_rd_lit;
    logic       w_blank;
    logic [7:0] w_col_hot;
    t_out_item  n_out;
    t_buf_wr    w_wr;
    logic [7:0] w_out_cols;

    assign w_is_tick  = r_in_valid && (r_in.action == ACT_TICK);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && (!w_is_tick || w_out_free);
    assign w_do_tick  = w_is_tick && w_out_free;
    assign w_do_write = r_in_valid && (r_in.action == ACT_WRITE);
    assign w_do_swap  = r_in_valid && (r_in.action == ACT_SWAP);
    assign o_in_ready = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    // Buffers swap on the tick that wraps the counter, if a swap is pending and no frame load is open.
    assign w_swap_now = w_do_tick && (r_scan == SCAN_LAST) && r_pending && !r_lock;

    // Row writes always land in the frame that is not on display.
    assign w_wr.en   = w_do_write;
    assign w_wr.addr = {~r_front, r_in.row_index};
    assign w_wr.data = r_in.row_data;

    assign w_col = r_scan[2:0];

    lmdbs_row_buf u_row_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_addr ({r_front, w_col}),
        .o_rd_row  (w_rd_row),
        .o_rd_lit  (w_rd_lit)
    );

    always_comb begin
        w_blank   = r_scan[3] && (w_rd_lit < r_dim);
        w_col_hot = 8'd1 << w_col;
        n_out.shown_buffer = r_front;
        if (w_blank) begin
            n_out.port_b_value = 2'd0;
            n_out.port_c_value = 6'd0;
            n_out.port_d_value = 8'd0;
        end else begin
            n_out.port_b_value = w_col_hot[7:6];
            n_out.port_c_value = w_col_hot[5:0];
            n_out.port_d_value = w_rd_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_do_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_tick) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan    <= 5'd0;
            r_front   <= 1'b0;
            r_pending <= 1'b0;
            r_lock    <= 1'b0;
        end else begin
            if (w_do_tick) begin
                r_scan <= r_scan + 5'd1;
            end
            if (w_swap_now) begin
                r_front   <= ~r_front;
                r_pending <= 1'b0;
            end else if (w_do_swap) begin
                r_pending <= 1'b1;
            end
            if (w_do_write) begin
                r_lock <= (r_in.row_index != ROW_LAST);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_RESET;
        end else if (i_cfg_valid) begin
            r_dim <= i_cfg_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_out_cols  = {r_out.port_b_value, r_out.port_c_value};

    `LMDBS_ASSERT_NEXT(a_front_only_on_wrap, !(w_do_tick && (r_scan == SCAN_LAST)),
        $stable(r_front), "front buffer changed away from a counter wrap")
    `LMDBS_ASSERT_NEXT(a_swap_clears_pending, w_swap_now,
        (r_front != $past(r_front)) && !r_pending, "swap did not take effect")
    `LMDBS_ASSERT_NEXT(a_stalled_request_held, r_in_valid && !w_advance,
        r_in_valid && $stable(r_in), "stalled request was lost or changed")
    `LMDBS_ASSERT_NOW(a_column_onehot, r_out_valid,
        $onehot0(w_out_cols), "column select is not one-hot or zero")
    `LMDBS_ASSERT_NOW(a_blank_clears_row, r_out_valid && (w_out_cols == 8'd0),
        r_out.port_d_value == 8'd0, "blanked result drives row data")

endmodule

// ----- tb/tb_top.sv -----
// -----------------------------------------------------------------------------
// LED matrix double buffer scanner testbench
// Drives row writes, swap requests and scan ticks through the request channel
// and checks each scan result against a cycle-free model of both frames or a scripted one.
// A short scripted sequence runs first, then randomized frame loads under
// varying dim thresholds and handshake pressure.
// -----------------------------------------------------------------------------
module tb_top;
    import lmdbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct {
        t_in_item  req;
        bit        known;
        t_out_item res;
    } t_script_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_data;

    // A scripted row may carry its own expected result alongside the request.
    logic      known_valid;
    t_out_item known_item;

    int send_idle_pct;
    int recv_stall_pct;
    int sent_count;
    int errors;
    int checked;
    int swaps_done;

    // Predicted state of the scanner.
    logic [7:0] frame_rows [16];
    logic [3:0] lit_counts [16];
    logic [4:0] scan_pos;
    logic       front_sel;
    logic       swap_req;
    logic       load_locked;
    logic [3:0] dim_level;

    t_out_item pending_scans [$];

    led_matrix_double_buffer_scanner u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Advances the predicted state by one request; returns 1 when a scan
    // result is produced.
    function automatic bit scan_step(input t_in_item req, output t_out_item res);
        logic [3:0] slot;
        logic [2:0] col;
        logic       blank;
        res = '0;
        case (req.action)
            ACT_WRITE: begin
                slot = {~front_sel, req.row_index};
                frame_rows[slot] = req.row_data;
                lit_counts[slot] = 4'($countones(req.row_data));
                load_locked = (req.row_index != ROW_LAST);
                return 1'b0;
            end
            ACT_SWAP: begin
                swap_req = 1'b1;
                return 1'b0;
            end
            ACT_TICK: begin
                col = scan_pos[2:0];
                slot = {front_sel, col};
                blank = scan_pos[3] && (lit_counts[slot] < dim_level);
                if (!blank) begin
                    if (col < 3'd6) begin
                        res.port_c_value = 6'(1 << col);
                    end else begin
                        res.port_b_value = 2'(1 << (col - 3'd6));
                    end
                    res.port_d_value = frame_rows[slot];
                end
                res.shown_buffer = front_sel;
                scan_pos = scan_pos + 5'd1;
                if (scan_pos == 5'd0 && swap_req && !load_locked) begin
                    front_sel = ~front_sel;
                    swap_req = 1'b0;
                    swaps_done++;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Results are retired before new requests are predicted, so a result can
    // never be matched against the request accepted at the same edge.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        t_out_item pred;
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                frame_rows[k] = '0;
                lit_counts[k] = '0;
            end
            scan_pos = '0;
            front_sel = 1'b0;
            swap_req = 1'b0;
            load_locked = 1'b0;
            dim_level = DIM_RESET;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = o_out_item;
                if (pending_scans.size() == 0) begin
                    $display("%0t: unexpected scan result %h", $realtime, got);
                    errors++;
                end else begin
                    want = pending_scans.pop_front();
                    checked++;
                    if (got.port_b_value !== want.port_b_value) begin
                        $display("%0t: port_b_value expected %h actual %h",
                                 $realtime, want.port_b_value, got.port_b_value);
                        errors++;
                    end
                    if (got.port_c_value !== want.port_c_value) begin
                        $display("%0t: port_c_value expected %h actual %h",
                                 $realtime, want.port_c_value, got.port_c_value);
                        errors++;
                    end
                    if (got.port_d_value !== want.port_d_value) begin
                        $display("%0t: port_d_value expected %h actual %h",
                                 $realtime, want.port_d_value, got.port_d_value);
                        errors++;
                    end
                    if (got.shown_buffer !== want.shown_buffer) begin
                        $display("%0t: shown_buffer expected %h actual %h",
                                 $realtime, want.shown_buffer, got.shown_buffer);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                dim_level = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                if (scan_step(i_in_item, pred)) begin
                    pending_scans.push_back(known_valid ? known_item : pred);
                end
            end
        end
    end

    task automatic send_req(input t_in_item req, input bit known, input t_out_item res);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= req;
        known_valid <= known;
        known_item <= res;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (req.action != ACT_NONE) begin
            sent_count++;
        end
    endtask

    // The extra edge keeps a lowered valid from being raised again in the
    // same time step.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_scans.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [3:0] level);
        hold_until_drained();
        // Writes and swaps leave no result, so give the pipeline time to settle.
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= level;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_script_row script [20];
        logic [3:0]  levels [6];
        t_in_item    req;
        int          nrows;
        int          pick;
        int          seq;
        int          n;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        known_valid = 1'b0;
        known_item = '0;
        send_idle_pct = 18;
        recv_stall_pct = 73;
        sent_count = 0;
        errors = 0;
        checked = 0;
        swaps_done = 0;

        // The front frame stays blank here, so every tick reads a zero row:
        // bright phases show only the column select, dim phases blank fully.
        script = '{
            '{{ACT_TICK,  3'd0, 8'h00}, 1'b1, {2'd0, 6'h01, 8'h00, 1'b0}},
            '{{ACT_WRITE, 3'd0, 8'hff}, 1'b0, '0},
            '{{ACT_WRITE, 3'd7, 8'h00}, 1'b0, '0},
            '{{ACT_NONE,  3'd5, 8'ha5}, 1'b0, '0},
            '{{ACT_TICK,  3'd0, 8'h00}, 1'b1, {2'd0, 6'h02, 8'h00, 1'b0}},
            '{{ACT_SWAP,  3'd0, 8'h00}, 1'b0, '0},
            '{{ACT_TICK,  3'd7, 8'hff}, 1'b1, {2'd0, 6'h04, 8'h00, 1'b0}},
            '{{ACT_TICK,  3'd0, 8'h00}, 1'b1, {2'd0, 6'h08, 8'h00, 1'b0}},
            '{{ACT_TICK,  3'd0, 8'h00}, 1'b1, {2'd0, 6'h10, 8'h00, 1'b0}},
            '{{ACT_TICK,  3'd0, 8'h00}, 1'b1, {2'd0, 6'h20, 8'h00, 1'b0}},
            '{{ACT_TICK,  3'd0, 8'h00}, 1'b1, {2'd1, 6'h00, 8'h00, 1'b0}},
            '{{ACT_TICK,  3'd0, 8'h00}, 1'b1, {2'd2, 6'h00, 8'h00, 1'b0}},
            '{{ACT_WRITE, 3'd3, 8'h55}, 1'b0, '0},
            '{{ACT_TICK,  3'd0, 8'h00}, 1'b1, '0},
            '{{ACT_TICK,  3'd0, 8'h00}, 1'b1, '0},
            '{{ACT_WRITE, 3'd7, 8'hff}, 1'b0, '0},
            '{{ACT_TICK,  3'd0, 8'h00}, 1'b1, '0},
            '{{ACT_NONE,  3'd7, 8'h00}, 1'b0, '0},
            '{{ACT_TICK,  3'd0, 8'h00}, 1'b1, '0},
            '{{ACT_WRITE, 3'd6, 8'h80}, 1'b0, '0}
        };
        levels = '{4'd0, 4'd15, 4'd8, 4'($urandom_range(1, 7)), 4'd9,
                   4'($urandom_range(15))};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            send_req(script[k].req, script[k].known, script[k].res);
        end

        for (int phase = 0; phase < 6; phase++) begin
            write_threshold(levels[phase]);
            send_idle_pct = (phase < 2) ? 18 : (phase < 4) ? 73 : 0;
            recv_stall_pct = (phase < 2) ? 73 : (phase < 4) ? 18 : 0;
            n = sent_count + 48;
            seq = 0;
            while (sent_count < n) begin
                if ((phase == 0 && seq == 2) || $urandom_range(7) == 0) begin
                    hold_until_drained();
                end
                pick = $urandom_range(9);
                // Mostly whole frames ending on the last row, which unlock the
                // swap; some frames stop early and leave the swap pending.
                nrows = (pick < 5) ? 8 : (pick < 7) ? $urandom_range(1, 7) : 0;
                for (int r = 0; r < nrows; r++) begin
                    req.action = ACT_WRITE;
                    req.row_index = 3'(r);
                    case ($urandom_range(3))
                        0: req.row_data = 8'h00;
                        1: req.row_data = 8'hff;
                        default: req.row_data = 8'($urandom_range(255));
                    endcase
                    send_req(req, 1'b0, '0);
                end
                if (pick < 8) begin
                    req = {ACT_SWAP, 3'($urandom_range(7)), 8'($urandom_range(255))};
                    send_req(req, 1'b0, '0);
                end
                if (pick >= 7) begin
                    repeat ($urandom_range(1, 4)) begin
                        req = {2'($urandom_range(3)), 3'($urandom_range(7)),
                               8'($urandom_range(255))};
                        send_req(req, 1'b0, '0);
                    end
                end
                repeat ($urandom_range(8, 48)) begin
                    req = {ACT_TICK, 3'($urandom_range(7)), 8'($urandom_range(255))};
                    send_req(req, 1'b0, '0);
                end
                seq++;
            end
        end

        i_in_valid <= 1'b0;
        for (int k = 0; k < 20000 && pending_scans.size() != 0; k++) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
        if (pending_scans.size() != 0) begin
            $display("%0t: %0d scan results never arrived", $realtime,
                     pending_scans.size());
            errors++;
        end

        $display("Sent %0d requests and checked %0d scan results across 7 dim levels,",
                 sent_count, checked);
        $display("with %0d frame swaps under sender and receiver stalls.", swaps_done);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout at %0t", $realtime);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- led_matrix_double_buffer_scanner.f -----
+incdir+sv
sv/lmdbs_pkg.sv
sv/lmdbs_row_buf.sv
sv/led_matrix_double_buffer_scanner.sv
tb/tb_top.sv
